// ===== rtl/rc4kx_pkg.sv =====
// Package for the RC4-variant keystream XOR unit.
// Holds opcodes, microcode word layout and the microcode program.
// Used by rc4kx_seq, rc4kx_dp and rc4_variant_keystream_xor_unit.
`default_nettype none

package rc4kx_pkg;

  localparam int MAX_KEY_BYTES_DEF = 256;
  localparam int SBOX_DEPTH        = 256;

  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  typedef logic [3:0] upc_t;

  localparam upc_t UPC_IDLE = 4'd0;
  localparam upc_t UPC_INIT = 4'd1;
  localparam upc_t UPC_KA   = 4'd2;
  localparam upc_t UPC_KB   = 4'd3;
  localparam upc_t UPC_KC   = 4'd4;
  localparam upc_t UPC_KD   = 4'd5;
  localparam upc_t UPC_D0   = 4'd6;
  localparam upc_t UPC_D1   = 4'd7;
  localparam upc_t UPC_D2   = 4'd8;
  localparam upc_t UPC_D3   = 4'd9;

  typedef enum logic [2:0] {
    RA_N,
    RA_JNEXT,
    RA_I,
    RA_ISUM,
    RA_SSUM
  } ra_sel_t;

  typedef enum logic {
    WA_N,
    WA_J
  } wa_sel_t;

  typedef enum logic [1:0] {
    WD_N,
    WD_RD,
    WD_T
  } wd_sel_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_LOOP_END,
    JMP_DONE
  } jmp_t;

  typedef struct packed {
    ra_sel_t ra;
    logic    we;
    wa_sel_t wa;
    wd_sel_t wd;
    logic    ld_j;
    logic    ld_t;
    logic    ld_si;
    logic    adv_n;
    logic    adv_k;
    logic    adv_pos;
    logic    emit;
    jmp_t    jmp;
    upc_t    target;
  } ucw_t;

  typedef struct packed {
    logic key_wr;
    logic sched_start;
    logic data_start;
  } cmd_t;

  function automatic ucw_t ucode(input upc_t pc);
    ucw_t w;
    w = '0;
    w.ra = RA_N;
    w.wa = WA_N;
    w.wd = WD_N;
    w.jmp = JMP_NEXT;
    w.target = UPC_IDLE;
    case (pc)
      UPC_IDLE: begin
        w.jmp = JMP_DONE;
      end
      UPC_INIT: begin
        w.we     = 1'b1;
        w.adv_n  = 1'b1;
        w.jmp    = JMP_LOOP;
        w.target = UPC_INIT;
      end
      UPC_KA: begin
        w.ra = RA_N;
      end
      UPC_KB: begin
        w.ra   = RA_JNEXT;
        w.ld_j = 1'b1;
        w.ld_t = 1'b1;
      end
      UPC_KC: begin
        w.we = 1'b1;
        w.wa = WA_N;
        w.wd = WD_RD;
      end
      UPC_KD: begin
        w.we     = 1'b1;
        w.wa     = WA_J;
        w.wd     = WD_T;
        w.adv_n  = 1'b1;
        w.adv_k  = 1'b1;
        w.jmp    = JMP_LOOP_END;
        w.target = UPC_KA;
      end
      UPC_D0: begin
        w.ra = RA_I;
      end
      UPC_D1: begin
        w.ra    = RA_ISUM;
        w.ld_si = 1'b1;
      end
      UPC_D2: begin
        w.ra = RA_SSUM;
      end
      UPC_D3: begin
        w.emit    = 1'b1;
        w.adv_pos = 1'b1;
        w.jmp     = JMP_DONE;
      end
      default: begin
        w.jmp = JMP_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rc4kx_seq.sv =====
// Microcode sequencer: program counter, control store lookup and jumps.
// Depends on rc4kx_pkg for the program and control word layout.
`default_nettype none

module rc4kx_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start_sched,
  input  wire logic            start_data,
  input  wire logic            hold,
  input  wire logic            last,
  output rc4kx_pkg::ucw_t      cw,
  output logic                 busy
);

  rc4kx_pkg::upc_t pc;
  rc4kx_pkg::upc_t pc_next;

  assign cw   = rc4kx_pkg::ucode(pc);
  assign busy = (pc != rc4kx_pkg::UPC_IDLE);

  always_comb begin
    pc_next = pc;
    if (hold) begin
      pc_next = pc;
    end else if (pc == rc4kx_pkg::UPC_IDLE) begin
      if (start_sched) begin
        pc_next = rc4kx_pkg::UPC_INIT;
      end else if (start_data) begin
        pc_next = rc4kx_pkg::UPC_D0;
      end
    end else begin
      case (cw.jmp)
        rc4kx_pkg::JMP_NEXT:     pc_next = pc + 4'd1;
        rc4kx_pkg::JMP_LOOP:     pc_next = last ? pc + 4'd1 : cw.target;
        rc4kx_pkg::JMP_LOOP_END: pc_next = last ? rc4kx_pkg::UPC_IDLE : cw.target;
        rc4kx_pkg::JMP_DONE:     pc_next = rc4kx_pkg::UPC_IDLE;
        default:                 pc_next = rc4kx_pkg::UPC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rc4kx_pkg::UPC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rc4kx_dp.sv =====
// Datapath: substitution box and key memories, index registers, key count.
// Driven by control words from rc4kx_seq; types from rc4kx_pkg.
`default_nettype none

module rc4kx_dp #(
  parameter int MAX_KEY_BYTES = rc4kx_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  rc4kx_pkg::cmd_t      cmd,
  input  wire logic [7:0]      in_byte,
  input  rc4kx_pkg::ucw_t      cw,
  input  wire logic            hold,
  output logic                 last,
  output logic                 scheduled,
  output logic [7:0]           xor_byte
);

  localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KCW = $clog2(MAX_KEY_BYTES + 1);

  logic [7:0]     sbox [rc4kx_pkg::SBOX_DEPTH];
  logic [7:0]     key_mem [MAX_KEY_BYTES];

  logic [7:0]     n;
  logic [7:0]     j;
  logic [7:0]     t;
  logic [7:0]     si;
  logic [7:0]     pos;
  logic [7:0]     rd;
  logic [7:0]     key_rd;
  logic [7:0]     data_byte;
  logic [KIW-1:0] kidx;
  logic [KCW-1:0] key_count;

  logic [7:0]     i_cur;
  logic [7:0]     kb;
  logic [7:0]     j_next;
  logic [7:0]     ra;
  logic [7:0]     wa;
  logic [7:0]     wd;
  logic [KIW-1:0] kidx_next;
  logic           key_full;

  assign last     = (n == 8'hFF);
  assign xor_byte = data_byte ^ rd;
  assign i_cur    = pos + 8'd1;
  assign kb       = (key_count == '0) ? 8'd0 : key_rd;
  assign j_next   = j + rd + kb;
  assign key_full = (key_count == KCW'(MAX_KEY_BYTES));
  assign kidx_next = ((KCW'(kidx) + KCW'(1)) == key_count) ? '0 : kidx + KIW'(1);

  always_comb begin
    case (cw.ra)
      rc4kx_pkg::RA_N:     ra = n;
      rc4kx_pkg::RA_JNEXT: ra = j_next;
      rc4kx_pkg::RA_I:     ra = i_cur;
      rc4kx_pkg::RA_ISUM:  ra = i_cur + rd;
      rc4kx_pkg::RA_SSUM:  ra = si + rd;
      default:             ra = n;
    endcase
    case (cw.wa)
      rc4kx_pkg::WA_N: wa = n;
      rc4kx_pkg::WA_J: wa = j;
      default:         wa = n;
    endcase
    case (cw.wd)
      rc4kx_pkg::WD_N:  wd = n;
      rc4kx_pkg::WD_RD: wd = rd;
      rc4kx_pkg::WD_T:  wd = t;
      default:          wd = n;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cw.we) begin
      sbox[wa] <= wd;
    end
    if (!hold) begin
      rd <= sbox[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_wr && !key_full) begin
      key_mem[key_count[KIW-1:0]] <= in_byte;
    end
    key_rd <= key_mem[kidx];
  end

  always_ff @(posedge clk) begin
    if (cw.ld_t) begin
      t <= rd;
    end
    if (cw.ld_si) begin
      si <= rd;
    end
    if (cmd.data_start) begin
      data_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      j         <= '0;
      kidx      <= '0;
      pos       <= '0;
      key_count <= '0;
      scheduled <= 1'b0;
    end else begin
      if (cmd.key_wr && !key_full) begin
        key_count <= key_count + KCW'(1);
      end
      if (cmd.sched_start) begin
        n         <= '0;
        j         <= '0;
        kidx      <= '0;
        pos       <= '0;
        scheduled <= 1'b1;
      end else begin
        if (cw.adv_n) begin
          n <= n + 8'd1;
        end
        if (cw.ld_j) begin
          j <= j_next;
        end
        if (cw.adv_k) begin
          kidx <= kidx_next;
        end
        if (cw.adv_pos && !hold) begin
          pos <= pos + 8'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rc4_variant_keystream_xor_unit.sv =====
// Top level of the RC4-variant keystream XOR unit: handshakes, output register.
// Instantiates rc4kx_seq and rc4kx_dp; uses rc4kx_pkg.
//
//   channel | signals                          | word
//   --------+----------------------------------+--------------------------
//   input   | in_valid, in_stall, op, in_byte  | key byte, schedule, data
//   output  | out_valid, out_stall, out_byte,  | one word per data byte
//           | keyed                            |
//
// Key byte: stored on accept unless the key memory is full. Schedule: busy after
// accept while the microcode fills the substitution box, then swaps each entry (KA-KD).
// Keyed data byte: three dependent box reads (D0-D3), result registered to out_byte;
// next word taken once the sequencer is idle. Unkeyed data passes through unchanged.
// Synchronous reset clears key count, position and the scheduled flag (not keyed).
// A stalled output holds the sequencer on its final step.
`default_nettype none

module rc4_variant_keystream_xor_unit #(
  parameter int MAX_KEY_BYTES = rc4kx_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] op,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            keyed
);

  rc4kx_pkg::ucw_t cw;
  rc4kx_pkg::cmd_t cmd;
  logic            busy;
  logic            hold;
  logic            last;
  logic            scheduled;
  logic [7:0]      xor_byte;
  logic            accept;
  logic            pass;
  logic            emit;

  assign in_stall = busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign hold     = cw.emit && out_valid && out_stall;
  assign emit     = cw.emit && !hold;

  assign cmd.key_wr      = accept && (op == rc4kx_pkg::OP_KEY);
  assign cmd.sched_start = accept && (op == rc4kx_pkg::OP_SCHED);
  assign cmd.data_start  = accept && (op == rc4kx_pkg::OP_DATA) && scheduled;
  assign pass            = accept && (op == rc4kx_pkg::OP_DATA) && !scheduled;

  rc4kx_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start_sched (cmd.sched_start),
    .start_data  (cmd.data_start),
    .hold        (hold),
    .last        (last),
    .cw          (cw),
    .busy        (busy)
  );

  rc4kx_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_byte   (in_byte),
    .cw        (cw),
    .hold      (hold),
    .last      (last),
    .scheduled (scheduled),
    .xor_byte  (xor_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pass || emit) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pass) begin
      out_byte <= in_byte;
      keyed    <= 1'b0;
    end else if (emit) begin
      out_byte <= xor_byte;
      keyed    <= 1'b1;
    end
  end

endmodule

`default_nettype wire
